FILE: src/newton_cube_root_macros.svh
// ---------------------------------------------------------------------------
// newton_cube_root_macros.svh
// assertion macros for the cube root block, compiled out with NO_ASSERTIONS
// ---------------------------------------------------------------------------
`ifndef NEWTON_CUBE_ROOT_MACROS_SVH
`define NEWTON_CUBE_ROOT_MACROS_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication, disabled in reset
`define NCR_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// next-cycle implication, disabled in reset
`define NCR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define NCR_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define NCR_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

FILE: src/ncr_pkg.sv
// ---------------------------------------------------------------------------
// ncr_pkg
// widths, constants and controller/datapath types for the cube root block
// ---------------------------------------------------------------------------
`default_nettype none

package ncr_pkg;

	// number formats
	localparam int WORD_W  = 32;          // operand word, Q16.16
	localparam int FRAC_W  = 16;
	localparam int GUESS_W = 32;          // guess is kept in 1 .. 2^32-1
	localparam int PROD_W  = 2 * GUESS_W; // Q32.32 square, Q48.16 quotient
	localparam int ROOT_W  = 23;
	localparam int ITER_W  = 6;
	localparam int TOL_W   = 5;

	// configuration port
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 6;
	localparam logic [CFG_IDX_W-1:0] REG_TOL_SHIFT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER  = 1'd1;
	localparam logic [TOL_W-1:0]     TOL_RESET      = 5'd14;
	localparam logic [ITER_W-1:0]    MAX_ITER_RESET = 6'd40;

	// sequencing of the two dividers
	localparam int DIV_CNT_W = $clog2(PROD_W);
	localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(PROD_W - 1);
	localparam int D3_BITS   = 8;                   // quotient bits per cycle, divide by 3
	localparam int D3_PASSES = PROD_W / D3_BITS;
	localparam int D3_CNT_W  = $clog2(D3_PASSES);
	localparam logic [D3_CNT_W-1:0] D3_LAST = D3_CNT_W'(D3_PASSES - 1);

	// arithmetic constants
	localparam int GUESS_SHIFT = 3;                 // first guess scales by 8
	localparam logic [2:0] THIRD_DIV = 3'd3;
	localparam logic [WORD_W-1:0]  ONE_RAW    = WORD_W'(64'd1 << FRAC_W);
	localparam logic [PROD_W-1:0]  Q_CAP      = PROD_W'(64'd1 << 62);
	localparam logic [GUESS_W-1:0] ROOT_LIMIT = GUESS_W'(64'd34 << FRAC_W);

	// controller to datapath
	typedef struct packed {
		logic              load_in;
		logic              mul;
		logic              div_step;
		logic              diff;
		logic              d3_step;
		logic              update;
		logic              load_out;
		logic [ITER_W-1:0] count;
		logic              cap;
	} ncr_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic zero;
		logic converged;
	} ncr_status_t;

endpackage

`default_nettype wire

FILE: src/ncr_if.sv
// ---------------------------------------------------------------------------
// ncr_if
// valid/ready channels of the cube root block: operand, result, config
// ---------------------------------------------------------------------------
`default_nettype none

interface ncr_in_if import ncr_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [WORD_W-1:0] value;

	modport source (output valid, output value, input ready);
	modport sink (input valid, input value, output ready);
endinterface

interface ncr_out_if import ncr_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [ROOT_W-1:0] root;
	logic [ITER_W-1:0]        iterations;
	logic                     cap_hit;

	modport source (output valid, output root, output iterations, output cap_hit,
		input ready);
	modport sink (input valid, input root, input iterations, input cap_hit,
		output ready);
endinterface

interface ncr_cfg_if import ncr_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: src/ncr_ctrl.sv
// ---------------------------------------------------------------------------
// ncr_ctrl
// sequencer: square, long division, divide by 3, update, stop test
// ---------------------------------------------------------------------------
`default_nettype none

module ncr_ctrl import ncr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  logic [ITER_W-1:0] max_iterations,
	input  ncr_status_t       status,
	output ncr_cmd_t          cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_MUL,
		S_DIV,
		S_DIFF,
		S_DIV3,
		S_UPDATE,
		S_FINISH
	} state_t;

	state_t               state_q;
	logic                 out_valid_q;
	logic [ITER_W-1:0]    count_q;
	logic                 cap_q;
	logic [DIV_CNT_W-1:0] div_cnt_q;
	logic [D3_CNT_W-1:0]  d3_cnt_q;
	logic [ITER_W-1:0]    count_n;

	assign count_n   = count_q + ITER_W'(1);
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd          = '0;
		cmd.load_in  = (state_q == S_IDLE) && in_valid;
		cmd.mul      = (state_q == S_MUL) && !status.zero;
		cmd.div_step = (state_q == S_DIV);
		cmd.diff     = (state_q == S_DIFF);
		cmd.d3_step  = (state_q == S_DIV3);
		cmd.update   = (state_q == S_UPDATE);
		cmd.load_out = (state_q == S_FINISH) && (!out_valid_q || out_ready);
		cmd.count    = count_q;
		cmd.cap      = cap_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			count_q     <= '0;
			cap_q       <= 1'b0;
			div_cnt_q   <= '0;
			d3_cnt_q    <= '0;
		end else begin
			// result register: filled on finish, emptied when taken
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						count_q <= '0;
						cap_q   <= 1'b0;
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					div_cnt_q <= '0;
					state_q   <= status.zero ? S_FINISH : S_DIV;
				end
				S_DIV: begin
					div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
					if (div_cnt_q == DIV_LAST) begin
						state_q <= S_DIFF;
					end
				end
				S_DIFF: begin
					d3_cnt_q <= '0;
					state_q  <= S_DIV3;
				end
				S_DIV3: begin
					d3_cnt_q <= d3_cnt_q + D3_CNT_W'(1);
					if (d3_cnt_q == D3_LAST) begin
						state_q <= S_UPDATE;
					end
				end
				S_UPDATE: begin
					count_q <= count_n;
					if (status.converged) begin
						state_q <= S_FINISH;
					end else if (count_n >= max_iterations) begin
						cap_q   <= 1'b1;
						state_q <= S_FINISH;
					end else begin
						state_q <= S_MUL;
					end
				end
				S_FINISH: begin
					if (!out_valid_q || out_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

FILE: src/ncr_datapath.sv
// ---------------------------------------------------------------------------
// ncr_datapath
// guess register, squarer, radix-2 divider, divide by 3, result register
// ---------------------------------------------------------------------------
`default_nettype none

module ncr_datapath import ncr_pkg::*; (
	input  logic                     clk,
	input  logic signed [WORD_W-1:0] value,
	input  logic [TOL_W-1:0]         tolerance_shift,
	input  ncr_cmd_t                 cmd,
	output ncr_status_t              status,
	output logic signed [ROOT_W-1:0] root,
	output logic [ITER_W-1:0]        iterations,
	output logic                     cap_hit
);

	// clamp a signed wide value to 1 .. 2^GUESS_W-1
	function automatic logic [GUESS_W-1:0] clamp_guess(input logic [PROD_W:0] v);
		logic [GUESS_W-1:0] r;
		if (v[PROD_W] || (v == '0)) begin
			r = GUESS_W'(1);
		end else if (|v[PROD_W-1:GUESS_W]) begin
			r = '1;
		end else begin
			r = v[GUESS_W-1:0];
		end
		return r;
	endfunction

	logic                 neg_q;
	logic                 zero_q;
	logic [WORD_W-1:0]    mag_q;
	logic [GUESS_W-1:0]   g_q;
	logic [PROD_W-1:0]    sq_q;
	logic [PROD_W-1:0]    rem_q;
	logic [PROD_W-1:0]    num_q;
	logic                 dneg_q;
	logic [PROD_W-1:0]    dm_q;
	logic [1:0]           r3_q;
	logic signed [ROOT_W-1:0] root_q;
	logic [ITER_W-1:0]    iter_q;
	logic                 cap_q;

	logic [WORD_W-1:0]    in_mag;
	logic [PROD_W:0]      init_ext;
	logic [GUESS_W-1:0]   init_guess;
	logic [PROD_W-1:0]    sq_c;
	logic [PROD_W-1:0]    numer;
	logic [PROD_W:0]      div_trial;
	logic [PROD_W:0]      div_sub;
	logic [PROD_W-1:0]    q_sat;
	logic [PROD_W-1:0]    g_ext;
	logic [PROD_W:0]      diff_w;
	logic [PROD_W-1:0]    diff_abs;
	logic [PROD_W-1:0]    d3_dm;
	logic [1:0]           d3_r;
	logic [2:0]           d3_t;
	logic                 d3_ge;
	logic [PROD_W:0]      upd_w;
	logic [GUESS_W-1:0]   g_new;
	logic [GUESS_W-1:0]   g_tol;
	logic [GUESS_W-1:0]   root_mag;
	logic [GUESS_W-1:0]   root_sgn;

	// magnitude; the most negative word maps to 2^(WORD_W-1) unsigned
	assign in_mag   = value[WORD_W-1] ? (~value + WORD_W'(1)) : value;
	assign init_ext = (PROD_W + 1)'(in_mag);
	assign init_guess = clamp_guess((in_mag > ONE_RAW) ? (init_ext >> GUESS_SHIFT)
		: (init_ext << GUESS_SHIFT));

	assign sq_c  = g_q * g_q;
	assign numer = {mag_q, {(2 * FRAC_W){1'b0}}};

	// one restoring division step: quotient bits shift into num_q
	assign div_trial = {rem_q, num_q[PROD_W-1]};
	assign div_sub   = div_trial - {1'b0, sq_q};

	// g - q as sign and magnitude
	assign q_sat    = (num_q > Q_CAP) ? Q_CAP : num_q;
	assign g_ext    = PROD_W'(g_q);
	assign diff_w   = {1'b0, g_ext} - {1'b0, q_sat};
	assign diff_abs = diff_w[PROD_W] ? (q_sat - g_ext) : diff_w[PROD_W-1:0];

	// divide by 3, several quotient bits per cycle
	always_comb begin
		d3_dm = dm_q;
		d3_r  = r3_q;
		d3_t  = '0;
		d3_ge = 1'b0;
		for (int i = 0; i < D3_BITS; i++) begin
			d3_t  = {d3_r, d3_dm[PROD_W-1]};
			d3_ge = (d3_t >= THIRD_DIV);
			d3_r  = d3_ge ? 2'(d3_t - THIRD_DIV) : d3_t[1:0];
			d3_dm = {d3_dm[PROD_W-2:0], d3_ge};
		end
	end

	// g - delta, delta carried as sign dneg_q and magnitude dm_q
	assign upd_w = dneg_q ? ({1'b0, g_ext} + {1'b0, dm_q}) : ({1'b0, g_ext} - {1'b0, dm_q});
	assign g_new = clamp_guess(upd_w);
	assign g_tol = g_new >> tolerance_shift;

	assign status.zero      = zero_q;
	assign status.converged = (dm_q == '0) || (PROD_W'(g_tol) > dm_q);

	assign root_mag = (g_q > ROOT_LIMIT) ? ROOT_LIMIT : g_q;
	assign root_sgn = neg_q ? (~root_mag + GUESS_W'(1)) : root_mag;

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			neg_q  <= value[WORD_W-1];
			zero_q <= (value == '0);
			mag_q  <= in_mag;
			g_q    <= init_guess;
		end
		if (cmd.mul) begin
			sq_q  <= sq_c;
			rem_q <= '0;
			num_q <= numer;
		end
		if (cmd.div_step) begin
			rem_q <= div_sub[PROD_W] ? div_trial[PROD_W-1:0] : div_sub[PROD_W-1:0];
			num_q <= {num_q[PROD_W-2:0], !div_sub[PROD_W]};
		end
		if (cmd.diff) begin
			dneg_q <= diff_w[PROD_W];
			dm_q   <= diff_abs;
			r3_q   <= '0;
		end
		if (cmd.d3_step) begin
			dm_q <= d3_dm;
			r3_q <= d3_r;
		end
		if (cmd.update) begin
			g_q <= g_new;
		end
		if (cmd.load_out) begin
			root_q <= zero_q ? '0 : root_sgn[ROOT_W-1:0];
			iter_q <= cmd.count;
			cap_q  <= cmd.cap;
		end
	end

	assign root       = root_q;
	assign iterations = iter_q;
	assign cap_hit    = cap_q;

endmodule

`default_nettype wire

FILE: src/newton_cube_root.sv
// ---------------------------------------------------------------------------
// newton_cube_root
// signed Q16.16 cube root by Newton iteration, with iteration cap flag
// ---------------------------------------------------------------------------
//
//  channel   role  payload                         request moves
//  operand   sink  value (32b signed Q16.16)       one operand
//  result    src   root (23b), iterations, cap_hit one result
//  cfg       sink  index (1b), data (6b)           one register write
//
//  one operand at a time; each Newton step runs the 32x32 squarer, the
//  radix-2 long division, g - q, the divide by 3 and then the update and
//  stop test, in that order; a zero operand skips the Newton steps
//  a finished result waits in the output register while the next operand
//  is taken in; the block stalls only when a second result is ready
//  arst_n clears the sequencer and loads the register defaults
//  (tolerance_shift 14, max_iterations 40)
//
`default_nettype none

`include "newton_cube_root_macros.svh"

module newton_cube_root import ncr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	ncr_cfg_if.sink    cfg,
	ncr_in_if.sink     operand,
	ncr_out_if.source  result
);

	// configuration registers
	logic [TOL_W-1:0]  tol_q;
	logic [ITER_W-1:0] max_it_q;

	// controller / datapath link
	ncr_cmd_t    cmd;
	ncr_status_t status;

	// the config port never stalls
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q    <= TOL_RESET;
			max_it_q <= MAX_ITER_RESET;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_TOL_SHIFT: tol_q    <= cfg.data[TOL_W-1:0];
				REG_MAX_ITER:  max_it_q <= cfg.data[ITER_W-1:0];
				default: ;
			endcase
		end
	end

	// sequencer: owns the operand and result handshakes, step count and cap flag
	ncr_ctrl u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (operand.valid),
		.in_ready       (operand.ready),
		.out_valid      (result.valid),
		.out_ready      (result.ready),
		.max_iterations (max_it_q),
		.status         (status),
		.cmd            (cmd)
	);

	// arithmetic and the result register
	ncr_datapath u_datapath (
		.clk             (clk),
		.value           (operand.value),
		.tolerance_shift (tol_q),
		.cmd             (cmd),
		.status          (status),
		.root            (result.root),
		.iterations      (result.iterations),
		.cap_hit         (result.cap_hit)
	);

	// block is busy right after it takes an operand
	`NCR_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, operand.valid && operand.ready, !operand.ready)

	// a capped result stopped exactly at the limit (a limit of zero acts as one)
	`NCR_ASSERT_IMPL(a_cap_at_limit, clk, arst_n, result.valid && result.cap_hit, (result.iterations == max_it_q) || ((max_it_q == '0) && (result.iterations == ITER_W'(1))))

	// no steps only for a zero operand
	`NCR_ASSERT_IMPL(a_zero_path, clk, arst_n, result.valid && (result.iterations == '0), (result.root == '0) && !result.cap_hit)

endmodule

`default_nettype wire
